### design/per_source_connection_limit_table_assert.svh
// Assertion macros shared by the connection limit table RTL.
// They expect signals named clock and reset in the enclosing module.
`ifndef PER_SOURCE_CONNECTION_LIMIT_TABLE_ASSERT_SVH
`define PER_SOURCE_CONNECTION_LIMIT_TABLE_ASSERT_SVH

// same-cycle implication
`define PSLT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSLT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pslt_pkg.sv
// ----------------------------------------------------------------------------
// pslt_pkg
// Types and codes of the per-source connection limit table.
// ----------------------------------------------------------------------------
`default_nettype none

package pslt_pkg;

   localparam int KEY_W = 33;
   localparam int LIM_W = 16;

   localparam logic [2:0] OP_CHECK  = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_GET    = 3'd4;

   localparam logic [1:0] KIND_HARD        = 2'd0;
   localparam logic [1:0] KIND_SOFT_GLOBAL = 2'd1;
   localparam logic [1:0] KIND_SOFT_LOCAL  = 2'd2;
   localparam logic [1:0] KIND_NONE        = 2'd3;

   localparam logic [1:0] VERDICT_ALLOW = 2'd0;
   localparam logic [1:0] VERDICT_HOST  = 2'd1;
   localparam logic [1:0] VERDICT_SITE  = 2'd2;

   localparam logic SCOPE_LOCAL  = 1'b0;
   localparam logic SCOPE_GLOBAL = 1'b1;

   localparam logic [1:0] SRC_SOFT    = 2'd0;
   localparam logic [1:0] SRC_HARD    = 2'd1;
   localparam logic [1:0] SRC_CLASS   = 2'd2;
   localparam logic [1:0] SRC_DEFAULT = 2'd3;

   localparam logic [1:0] CSR_HOST_LOCAL  = 2'd0;
   localparam logic [1:0] CSR_HOST_GLOBAL = 2'd1;
   localparam logic [1:0] CSR_SITE_LOCAL  = 2'd2;
   localparam logic [1:0] CSR_SITE_GLOBAL = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] address;
      logic        key_is_site;
      logic        is_local;
      logic [15:0] class_host_limit;
      logic [15:0] class_site_limit;
      logic [1:0]  limit_kind;
      logic [15:0] limit_value;
   } req_type;

   typedef struct packed {
      logic        table_full;
      logic [15:0] soft_local_limit;
      logic [15:0] soft_global_limit;
      logic [15:0] hard_limit;
      logic [15:0] old_limit;
      logic [1:0]  verdict_source;
      logic        verdict_scope;
      logic [1:0]  verdict;
   } rsp_type;

   typedef struct packed {
      logic [15:0] host_local;
      logic [15:0] host_global;
      logic [15:0] site_local;
      logic [15:0] site_global;
   } cfg_type;

   typedef struct packed {
      logic h_hit;
      logic s_hit;
      logic f1_ok;
      logic f2_ok;
   } scan_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_WR_S,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### design/pslt_ram.sv
// ----------------------------------------------------------------------------
// pslt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### design/pslt_scan.sv
// ----------------------------------------------------------------------------
// pslt_scan
// Sweeps the table once, finds the host and site entries and two free slots.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_scan #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int ENTRY_W       = 114
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [pslt_pkg::KEY_W-1:0]       host_key,
   input  wire logic [pslt_pkg::KEY_W-1:0]       site_key,
   output logic                                  rd_en,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  wire logic [ENTRY_W-1:0]               rd_data,
   output logic                                  done,
   output pslt_pkg::scan_status_type             status,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] h_idx,
   output logic      [ENTRY_W-1:0]               h_data,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] s_idx,
   output logic      [ENTRY_W-1:0]               s_data,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] f1_idx,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] f2_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic                      active_ff;
   logic [IDX_W:0]            cnt_ff;
   logic                      rvalid_ff;
   logic [IDX_W-1:0]          ridx_ff;
   logic                      done_ff;
   pslt_pkg::scan_status_type status_ff;
   logic [IDX_W-1:0]          h_idx_ff, s_idx_ff, f1_ff, f2_ff;
   logic [ENTRY_W-1:0]        h_data_ff, s_data_ff;
   logic                      at_end;
   logic                      ent_v;
   logic [pslt_pkg::KEY_W-1:0] ent_key;

   assign at_end  = (cnt_ff == (IDX_W+1)'(TABLE_ENTRIES));
   assign rd_en   = active_ff && !at_end;
   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign ent_v   = rd_data[0];
   assign ent_key = rd_data[pslt_pkg::KEY_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
         status_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
            status_ff <= '0;
         end else if (active_ff) begin
            if (!at_end) begin
               cnt_ff    <= cnt_ff + 1'b1;
               rvalid_ff <= 1'b1;
               ridx_ff   <= cnt_ff[IDX_W-1:0];
            end else begin
               rvalid_ff <= 1'b0;
               if (!rvalid_ff) begin
                  active_ff <= 1'b0;
                  done_ff   <= 1'b1;
               end
            end
         end
         if (rvalid_ff) begin
            if (ent_v && ent_key == host_key) begin
               status_ff.h_hit <= 1'b1;
               h_idx_ff        <= ridx_ff;
               h_data_ff       <= rd_data;
            end
            if (ent_v && ent_key == site_key) begin
               status_ff.s_hit <= 1'b1;
               s_idx_ff        <= ridx_ff;
               s_data_ff       <= rd_data;
            end
            if (!ent_v) begin
               if (!status_ff.f1_ok) begin
                  status_ff.f1_ok <= 1'b1;
                  f1_ff           <= ridx_ff;
               end else if (!status_ff.f2_ok) begin
                  status_ff.f2_ok <= 1'b1;
                  f2_ff           <= ridx_ff;
               end
            end
         end
      end
   end

   assign done   = done_ff;
   assign status = status_ff;
   assign h_idx  = h_idx_ff;
   assign h_data = h_data_ff;
   assign s_idx  = s_idx_ff;
   assign s_data = s_data_ff;
   assign f1_idx = f1_ff;
   assign f2_idx = f2_ff;

endmodule

`default_nettype wire

### design/pslt_eval.sv
// ----------------------------------------------------------------------------
// pslt_eval
// Works out the result and the entry write-backs from the scanned entries.
// ----------------------------------------------------------------------------
`default_nettype none

module pslt_eval #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  wire pslt_pkg::req_type                req,
   input  wire pslt_pkg::cfg_type                cfg,
   input  wire logic [pslt_pkg::KEY_W-1:0]       host_key,
   input  wire logic [pslt_pkg::KEY_W-1:0]       site_key,
   input  wire pslt_pkg::scan_status_type        status,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] h_idx,
   input  wire logic [82+2*COUNT_BITS-1:0]       h_data,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] s_idx,
   input  wire logic [82+2*COUNT_BITS-1:0]       s_data,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] f1_idx,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] f2_idx,
   output pslt_pkg::rsp_type                     rsp,
   output logic                                  wh_en,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] wh_idx,
   output logic      [82+2*COUNT_BITS-1:0]       wh_data,
   output logic                                  ws_en,
   output logic      [$clog2(TABLE_ENTRIES)-1:0] ws_idx,
   output logic      [82+2*COUNT_BITS-1:0]       ws_data
);

   localparam int C       = COUNT_BITS;
   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W = 82 + 2*C;
   localparam int GC_L    = 34;
   localparam int LC_L    = 34 + C;
   localparam int HL_L    = 34 + 2*C;
   localparam int SG_L    = 50 + 2*C;
   localparam int SL_L    = 66 + 2*C;
   localparam int CMP_W   = (C > 16) ? C : 16;

   function automatic logic reached(input logic [C-1:0] cnt, input logic [15:0] lim);
      return CMP_W'(cnt) >= CMP_W'(lim);
   endfunction

   function automatic logic [C-1:0] inc_sat(input logic [C-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [C-1:0] dec_sat(input logic [C-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

   function automatic logic [ENTRY_W-1:0] fresh(input logic [pslt_pkg::KEY_W-1:0] key);
      return ENTRY_W'({key, 1'b1});
   endfunction

   function automatic logic [ENTRY_W-1:0] settle(input logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] r;
      r    = e;
      r[0] = !(e[GC_L +: C] == '0 && e[HL_L +: 16] == '0 &&
               e[SG_L +: 16] == '0 && e[SL_L +: 16] == '0);
      return r;
   endfunction

   always_comb begin
      logic               fired;
      logic [1:0]         lpri, gpri;
      logic [15:0]        lim;
      logic [1:0]         src;
      logic               has;
      logic               e_hit;
      logic [ENTRY_W-1:0] e;
      logic [ENTRY_W-1:0] hs_e, ss_e;
      logic               ok;
      rsp     = '0;
      wh_en   = 1'b0;
      wh_idx  = h_idx;
      wh_data = h_data;
      ws_en   = 1'b0;
      ws_idx  = s_idx;
      ws_data = s_data;
      fired   = 1'b0;
      lpri    = 2'd0;
      gpri    = 2'd0;
      lim     = '0;
      src     = pslt_pkg::SRC_SOFT;
      has     = 1'b0;
      e_hit   = 1'b0;
      e       = '0;
      hs_e    = '0;
      ss_e    = '0;
      ok      = 1'b0;
      unique case (req.opcode)
         pslt_pkg::OP_CHECK: begin
            if (status.h_hit) begin
               if (h_data[SL_L +: 16] != '0) begin
                  lpri = 2'd3; lim = h_data[SL_L +: 16]; src = pslt_pkg::SRC_SOFT;
               end else if (h_data[HL_L +: 16] != '0) begin
                  lpri = 2'd2; lim = h_data[HL_L +: 16]; src = pslt_pkg::SRC_HARD;
               end else if (req.class_host_limit != '0) begin
                  lpri = 2'd2; lim = req.class_host_limit; src = pslt_pkg::SRC_CLASS;
               end else begin
                  lpri = 2'd1; lim = cfg.host_local; src = pslt_pkg::SRC_DEFAULT;
               end
               if (reached(h_data[LC_L +: C], lim)) begin
                  fired = 1'b1;
                  rsp.verdict        = pslt_pkg::VERDICT_HOST;
                  rsp.verdict_scope  = pslt_pkg::SCOPE_LOCAL;
                  rsp.verdict_source = src;
               end
               if (h_data[SG_L +: 16] != '0) begin
                  gpri = 2'd3; lim = h_data[SG_L +: 16]; src = pslt_pkg::SRC_SOFT;
               end else if (h_data[HL_L +: 16] != '0) begin
                  gpri = 2'd2; lim = h_data[HL_L +: 16]; src = pslt_pkg::SRC_HARD;
               end else begin
                  gpri = 2'd1; lim = cfg.host_global; src = pslt_pkg::SRC_DEFAULT;
               end
               if (!fired && reached(h_data[GC_L +: C], lim)) begin
                  fired = 1'b1;
                  rsp.verdict        = pslt_pkg::VERDICT_HOST;
                  rsp.verdict_scope  = pslt_pkg::SCOPE_GLOBAL;
                  rsp.verdict_source = src;
               end
            end
            if (status.s_hit && !fired) begin
               has = 1'b1;
               if (s_data[SL_L +: 16] != '0) begin
                  lim = s_data[SL_L +: 16]; src = pslt_pkg::SRC_SOFT;
               end else if (s_data[HL_L +: 16] != '0) begin
                  lim = s_data[HL_L +: 16]; src = pslt_pkg::SRC_HARD;
               end else if (lpri <= 2'd2 && req.class_site_limit != '0) begin
                  lim = req.class_site_limit; src = pslt_pkg::SRC_CLASS;
               end else if (lpri <= 2'd1) begin
                  lim = cfg.site_local; src = pslt_pkg::SRC_DEFAULT;
               end else begin
                  has = 1'b0;
               end
               if (has && reached(s_data[LC_L +: C], lim)) begin
                  fired = 1'b1;
                  rsp.verdict        = pslt_pkg::VERDICT_SITE;
                  rsp.verdict_scope  = pslt_pkg::SCOPE_LOCAL;
                  rsp.verdict_source = src;
               end
               has = 1'b1;
               if (s_data[SG_L +: 16] != '0) begin
                  lim = s_data[SG_L +: 16]; src = pslt_pkg::SRC_SOFT;
               end else if (s_data[HL_L +: 16] != '0) begin
                  lim = s_data[HL_L +: 16]; src = pslt_pkg::SRC_HARD;
               end else if (gpri <= 2'd1) begin
                  lim = cfg.site_global; src = pslt_pkg::SRC_DEFAULT;
               end else begin
                  has = 1'b0;
               end
               if (!fired && has && reached(s_data[GC_L +: C], lim)) begin
                  rsp.verdict        = pslt_pkg::VERDICT_SITE;
                  rsp.verdict_scope  = pslt_pkg::SCOPE_GLOBAL;
                  rsp.verdict_source = src;
               end
            end
         end
         pslt_pkg::OP_ADD: begin
            ok = 1'b1;
            if (!status.h_hit && !status.f1_ok) begin
               ok = 1'b0;
            end else if (!status.s_hit) begin
               ok = status.h_hit ? status.f1_ok : status.f2_ok;
            end
            rsp.table_full = !ok;
            hs_e = status.h_hit ? h_data : fresh(host_key);
            ss_e = status.s_hit ? s_data : fresh(site_key);
            hs_e[GC_L +: C] = inc_sat(hs_e[GC_L +: C]);
            ss_e[GC_L +: C] = inc_sat(ss_e[GC_L +: C]);
            if (req.is_local) begin
               hs_e[LC_L +: C] = inc_sat(hs_e[LC_L +: C]);
               ss_e[LC_L +: C] = inc_sat(ss_e[LC_L +: C]);
            end
            wh_en   = ok;
            wh_idx  = status.h_hit ? h_idx : f1_idx;
            wh_data = hs_e;
            ws_en   = ok;
            ws_idx  = status.s_hit ? s_idx : (status.h_hit ? f1_idx : f2_idx);
            ws_data = ss_e;
         end
         pslt_pkg::OP_REMOVE: begin
            hs_e = h_data;
            ss_e = s_data;
            hs_e[GC_L +: C] = dec_sat(hs_e[GC_L +: C]);
            ss_e[GC_L +: C] = dec_sat(ss_e[GC_L +: C]);
            if (req.is_local) begin
               hs_e[LC_L +: C] = dec_sat(hs_e[LC_L +: C]);
               ss_e[LC_L +: C] = dec_sat(ss_e[LC_L +: C]);
            end
            wh_en   = status.h_hit;
            wh_data = settle(hs_e);
            ws_en   = status.s_hit;
            ws_data = settle(ss_e);
         end
         pslt_pkg::OP_SET: begin
            e_hit = req.key_is_site ? status.s_hit : status.h_hit;
            ok    = e_hit || status.f1_ok;
            rsp.table_full = !ok;
            if (e_hit) begin
               e = req.key_is_site ? s_data : h_data;
            end else begin
               e = fresh(req.key_is_site ? site_key : host_key);
            end
            unique case (req.limit_kind)
               pslt_pkg::KIND_HARD: begin
                  rsp.old_limit = e[HL_L +: 16];
                  e[HL_L +: 16] = req.limit_value;
                  if (req.limit_value != '0 && e[SG_L +: 16] > req.limit_value) begin
                     e[SG_L +: 16] = '0;
                  end
               end
               pslt_pkg::KIND_SOFT_GLOBAL: begin
                  rsp.old_limit = e[SG_L +: 16];
                  e[SG_L +: 16] = req.limit_value;
               end
               pslt_pkg::KIND_SOFT_LOCAL: begin
                  rsp.old_limit = e[SL_L +: 16];
                  e[SL_L +: 16] = req.limit_value;
               end
               default: begin
               end
            endcase
            if (!ok) begin
               rsp.old_limit = '0;
            end
            wh_en = ok;
            if (e_hit) begin
               wh_idx = req.key_is_site ? s_idx : h_idx;
            end else begin
               wh_idx = f1_idx;
            end
            wh_data = settle(e);
         end
         pslt_pkg::OP_GET: begin
            e_hit = req.key_is_site ? status.s_hit : status.h_hit;
            e     = req.key_is_site ? s_data : h_data;
            if (e_hit) begin
               rsp.hard_limit        = e[HL_L +: 16];
               rsp.soft_global_limit = e[SG_L +: 16];
               rsp.soft_local_limit  = e[SL_L +: 16];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### design/per_source_connection_limit_table.sv
// ----------------------------------------------------------------------------
// per_source_connection_limit_table
// Connection limit table keyed by host address and /24 site prefix.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one operation per transaction (check, add, remove, set
//  limit, get limits); rsp_* returns exactly one result per operation.
//  csr_* writes the four default limits; write only while the block is idle.
//  Each operation sweeps the whole table through the read port of the entry
//  RAM, one entry a cycle, to find the host entry, the site entry and two
//  free slots, then writes back up to two entries.
//  One operation is in flight at a time; req_tready is high while idle, also
//  while a previous result still waits in the rsp register.
//  After reset a clearing pass empties the table, writing zero to every entry;
//  req_tready stays low until it ends. A stalled rsp_tready holds the result
//  and the block finishes the current operation, then waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_connection_limit_table #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // address, key_is_site, is_local, class_host_limit, class_site_limit,
   // limit_kind, limit_value (lowest bit up), zero pad
   input  wire logic [87:0] req_tdata,
   // opcode
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // verdict, verdict_scope, verdict_source, old_limit, hard_limit,
   // soft_global_limit, soft_local_limit, table_full (lowest bit up), zero pad
   output logic      [71:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

`include "per_source_connection_limit_table_assert.svh"

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W = 82 + 2*COUNT_BITS;

   pslt_pkg::state_type       state_ff, state_in;
   pslt_pkg::req_type         req_ff;
   pslt_pkg::cfg_type         cfg_ff;
   pslt_pkg::rsp_type         res_ff, res_in;
   pslt_pkg::scan_status_type status;
   logic [IDX_W-1:0]          clr_ff;
   logic                      rsp_tvalid_ff;
   pslt_pkg::rsp_type         rsp_ff;
   logic                      ws_en_ff;
   logic [IDX_W-1:0]          ws_idx_ff;
   logic [ENTRY_W-1:0]        ws_data_ff;

   logic                      accept;
   logic [pslt_pkg::KEY_W-1:0] host_key, site_key;
   logic                      scan_rd_en, scan_done;
   logic [IDX_W-1:0]          scan_rd_addr;
   logic [ENTRY_W-1:0]        ram_rdata;
   logic [IDX_W-1:0]          h_idx, s_idx, f1_idx, f2_idx;
   logic [ENTRY_W-1:0]        h_data, s_data;
   logic                      wh_en, ws_en;
   logic [IDX_W-1:0]          wh_idx, ws_idx;
   logic [ENTRY_W-1:0]        wh_data, ws_data;
   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [ENTRY_W-1:0]        ram_wdata;
   logic                      rsp_load;

   assign req_tready = (state_ff == pslt_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign host_key   = {1'b0, req_ff.address};
   assign site_key   = {1'b1, req_ff.address[31:8], 8'h00};
   assign rsp_load   = (state_ff == pslt_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pslt_pkg::CSR_HOST_LOCAL:  cfg_ff.host_local  <= csr_wdata;
            pslt_pkg::CSR_HOST_GLOBAL: cfg_ff.host_global <= csr_wdata;
            pslt_pkg::CSR_SITE_LOCAL:  cfg_ff.site_local  <= csr_wdata;
            pslt_pkg::CSR_SITE_GLOBAL: cfg_ff.site_global <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pslt_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pslt_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= {req_tuser, req_tdata[31:0], req_tdata[32], req_tdata[33],
                    req_tdata[49:34], req_tdata[65:50], req_tdata[67:66],
                    req_tdata[83:68]};
      end
      if (state_ff == pslt_pkg::ST_EXEC) begin
         res_ff     <= res_in;
         ws_en_ff   <= ws_en;
         ws_idx_ff  <= ws_idx;
         ws_data_ff <= ws_data;
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_waddr = wh_idx;
      ram_wdata = wh_data;
      unique case (state_ff)
         pslt_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = pslt_pkg::ST_IDLE;
            end
         end
         pslt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pslt_pkg::ST_SCAN;
            end
         end
         pslt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = pslt_pkg::ST_EXEC;
            end
         end
         pslt_pkg::ST_EXEC: begin
            ram_we   = wh_en;
            state_in = pslt_pkg::ST_WR_S;
         end
         pslt_pkg::ST_WR_S: begin
            ram_we    = ws_en_ff;
            ram_waddr = ws_idx_ff;
            ram_wdata = ws_data_ff;
            state_in  = pslt_pkg::ST_DONE;
         end
         pslt_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = pslt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pslt_pkg::ST_IDLE;
         end
      endcase
   end

   pslt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (scan_rd_en),
      .raddr (scan_rd_addr),
      .rdata (ram_rdata)
   );

   pslt_scan #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ENTRY_W       (ENTRY_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .host_key (host_key),
      .site_key (site_key),
      .rd_en    (scan_rd_en),
      .rd_addr  (scan_rd_addr),
      .rd_data  (ram_rdata),
      .done     (scan_done),
      .status   (status),
      .h_idx    (h_idx),
      .h_data   (h_data),
      .s_idx    (s_idx),
      .s_data   (s_data),
      .f1_idx   (f1_idx),
      .f2_idx   (f2_idx)
   );

   pslt_eval #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_eval (
      .req      (req_ff),
      .cfg      (cfg_ff),
      .host_key (host_key),
      .site_key (site_key),
      .status   (status),
      .h_idx    (h_idx),
      .h_data   (h_data),
      .s_idx    (s_idx),
      .s_data   (s_data),
      .f1_idx   (f1_idx),
      .f2_idx   (f2_idx),
      .rsp      (res_in),
      .wh_en    (wh_en),
      .wh_idx   (wh_idx),
      .wh_data  (wh_data),
      .ws_en    (ws_en),
      .ws_idx   (ws_idx),
      .ws_data  (ws_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.table_full, rsp_ff.soft_local_limit,
                        rsp_ff.soft_global_limit, rsp_ff.hard_limit, rsp_ff.old_limit,
                        rsp_ff.verdict_source, rsp_ff.verdict_scope, rsp_ff.verdict};

   `PSLT_ASSERT_IMP(a_ram_write_phase, ram_we, (state_ff == pslt_pkg::ST_CLEAR || state_ff == pslt_pkg::ST_EXEC || state_ff == pslt_pkg::ST_WR_S), "RAM written outside a write phase")
   `PSLT_ASSERT_IMP(a_two_writes_distinct, (state_ff == pslt_pkg::ST_EXEC && wh_en && ws_en), (wh_idx != ws_idx), "host and site write-back hit the same slot")
   `PSLT_ASSERT_NXT(a_rsp_from_done, (state_ff != pslt_pkg::ST_DONE && !rsp_tvalid), !rsp_tvalid, "result raised without a finished operation")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection limit table testbench
// Drives check, add, remove, set and get transactions into the table, keeps
// its own copy of the host and /24 site entries and of the default limits,
// and compares every result field by field against that copy. Covers a
// directed opening, random phases over a small address pool under several
// default settings, and a final phase that fills the table.
// ----------------------------------------------------------------------------

class limit_scoreboard;
   localparam int ENTRIES = 1024;
   localparam int unsigned CNT_MAX = 65535;

   bit          used [ENTRIES];
   logic [32:0] key_of [ENTRIES];
   int unsigned gcnt [ENTRIES];
   int unsigned lcnt [ENTRIES];
   int unsigned hard [ENTRIES];
   int unsigned softg [ENTRIES];
   int unsigned softl [ENTRIES];
   int unsigned dfl [4];
   pslt_pkg::rsp_type pending_results [$];
   int          mismatches;

   function void write_default(logic [1:0] idx, logic [15:0] val);
      dfl[idx] = val;
   endfunction

   function int used_count();
      int n;
      n = 0;
      foreach (used[i]) n += used[i];
      return n;
   endfunction

   function int find(logic [32:0] k);
      foreach (used[i]) if (used[i] && key_of[i] == k) return i;
      return -1;
   endfunction

   function int find_free(int skip);
      foreach (used[i]) if (!used[i] && i != skip) return i;
      return -1;
   endfunction

   function void create(int e, logic [32:0] k);
      used[e] = 1; key_of[e] = k;
      gcnt[e] = 0; lcnt[e] = 0; hard[e] = 0; softg[e] = 0; softl[e] = 0;
   endfunction

   function void release_if_empty(int e);
      if (gcnt[e] == 0 && hard[e] == 0 && softg[e] == 0 && softl[e] == 0) used[e] = 0;
   endfunction

   function bit fire(int unsigned cnt, int unsigned lim, logic [1:0] v, logic sc,
                     logic [1:0] src, inout pslt_pkg::rsp_type r);
      if (cnt < lim) return 0;
      r.verdict = v; r.verdict_scope = sc; r.verdict_source = src;
      return 1;
   endfunction

   function pslt_pkg::rsp_type check_cascade(pslt_pkg::req_type q);
      pslt_pkg::rsp_type r;
      int h, s, lp, gp;
      r = '0;
      h = find({1'b0, q.address});
      s = find({1'b1, q.address[31:8], 8'h00});
      lp = 0; gp = 0;
      if (h >= 0) begin
         if (softl[h] != 0) begin
            lp = 3;
            if (fire(lcnt[h], softl[h], pslt_pkg::VERDICT_HOST, pslt_pkg::SCOPE_LOCAL,
                     pslt_pkg::SRC_SOFT, r)) return r;
         end else if (hard[h] != 0) begin
            lp = 2;
            if (fire(lcnt[h], hard[h], pslt_pkg::VERDICT_HOST, pslt_pkg::SCOPE_LOCAL,
                     pslt_pkg::SRC_HARD, r)) return r;
         end else if (q.class_host_limit != 0) begin
            lp = 2;
            if (fire(lcnt[h], q.class_host_limit, pslt_pkg::VERDICT_HOST,
                     pslt_pkg::SCOPE_LOCAL, pslt_pkg::SRC_CLASS, r))
               return r;
         end else begin
            lp = 1;
            if (fire(lcnt[h], dfl[pslt_pkg::CSR_HOST_LOCAL], pslt_pkg::VERDICT_HOST,
                     pslt_pkg::SCOPE_LOCAL, pslt_pkg::SRC_DEFAULT, r))
               return r;
         end
         if (softg[h] != 0) begin
            gp = 3;
            if (fire(gcnt[h], softg[h], pslt_pkg::VERDICT_HOST, pslt_pkg::SCOPE_GLOBAL,
                     pslt_pkg::SRC_SOFT, r)) return r;
         end else if (hard[h] != 0) begin
            gp = 2;
            if (fire(gcnt[h], hard[h], pslt_pkg::VERDICT_HOST, pslt_pkg::SCOPE_GLOBAL,
                     pslt_pkg::SRC_HARD, r)) return r;
         end else begin
            gp = 1;
            if (fire(gcnt[h], dfl[pslt_pkg::CSR_HOST_GLOBAL], pslt_pkg::VERDICT_HOST,
                     pslt_pkg::SCOPE_GLOBAL, pslt_pkg::SRC_DEFAULT, r))
               return r;
         end
      end
      if (s >= 0) begin
         if (softl[s] != 0) begin
            if (fire(lcnt[s], softl[s], pslt_pkg::VERDICT_SITE, pslt_pkg::SCOPE_LOCAL,
                     pslt_pkg::SRC_SOFT, r)) return r;
         end else if (hard[s] != 0) begin
            if (fire(lcnt[s], hard[s], pslt_pkg::VERDICT_SITE, pslt_pkg::SCOPE_LOCAL,
                     pslt_pkg::SRC_HARD, r)) return r;
         end else if (lp <= 2 && q.class_site_limit != 0) begin
            if (fire(lcnt[s], q.class_site_limit, pslt_pkg::VERDICT_SITE,
                     pslt_pkg::SCOPE_LOCAL, pslt_pkg::SRC_CLASS, r))
               return r;
         end else if (lp <= 1) begin
            if (fire(lcnt[s], dfl[pslt_pkg::CSR_SITE_LOCAL], pslt_pkg::VERDICT_SITE,
                     pslt_pkg::SCOPE_LOCAL, pslt_pkg::SRC_DEFAULT, r))
               return r;
         end
         if (softg[s] != 0) begin
            if (fire(gcnt[s], softg[s], pslt_pkg::VERDICT_SITE, pslt_pkg::SCOPE_GLOBAL,
                     pslt_pkg::SRC_SOFT, r)) return r;
         end else if (hard[s] != 0) begin
            if (fire(gcnt[s], hard[s], pslt_pkg::VERDICT_SITE, pslt_pkg::SCOPE_GLOBAL,
                     pslt_pkg::SRC_HARD, r)) return r;
         end else if (gp <= 1) begin
            if (fire(gcnt[s], dfl[pslt_pkg::CSR_SITE_GLOBAL], pslt_pkg::VERDICT_SITE,
                     pslt_pkg::SCOPE_GLOBAL, pslt_pkg::SRC_DEFAULT, r))
               return r;
         end
      end
      return r;
   endfunction

   function pslt_pkg::rsp_type apply_operation(pslt_pkg::req_type q);
      pslt_pkg::rsp_type r;
      logic [32:0] hk, sk, k;
      int h, s, nh, ns, e;
      r = '0;
      hk = {1'b0, q.address};
      sk = {1'b1, q.address[31:8], 8'h00};
      k = q.key_is_site ? sk : hk;
      case (q.opcode)
         pslt_pkg::OP_CHECK: r = check_cascade(q);
         pslt_pkg::OP_ADD: begin
            h = find(hk); s = find(sk); nh = -1; ns = -1;
            if (h < 0) begin
               nh = find_free(-1);
               if (nh < 0) begin r.table_full = 1; return r; end
            end
            if (s < 0) begin
               ns = find_free(nh);
               if (ns < 0) begin r.table_full = 1; return r; end
            end
            if (h < 0) begin create(nh, hk); h = nh; end
            if (s < 0) begin create(ns, sk); s = ns; end
            if (gcnt[h] < CNT_MAX) gcnt[h]++;
            if (gcnt[s] < CNT_MAX) gcnt[s]++;
            if (q.is_local) begin
               if (lcnt[h] < CNT_MAX) lcnt[h]++;
               if (lcnt[s] < CNT_MAX) lcnt[s]++;
            end
         end
         pslt_pkg::OP_REMOVE: begin
            h = find(hk); s = find(sk);
            if (h >= 0) begin
               if (gcnt[h] != 0) gcnt[h]--;
               if (q.is_local && lcnt[h] != 0) lcnt[h]--;
               release_if_empty(h);
            end
            if (s >= 0) begin
               if (gcnt[s] != 0) gcnt[s]--;
               if (q.is_local && lcnt[s] != 0) lcnt[s]--;
               release_if_empty(s);
            end
         end
         pslt_pkg::OP_SET: begin
            e = find(k);
            if (e < 0) begin
               e = find_free(-1);
               if (e < 0) begin r.table_full = 1; return r; end
               create(e, k);
            end
            case (q.limit_kind)
               pslt_pkg::KIND_HARD: begin
                  r.old_limit = hard[e];
                  hard[e] = q.limit_value;
                  if (q.limit_value != 0 && softg[e] > q.limit_value) softg[e] = 0;
               end
               pslt_pkg::KIND_SOFT_GLOBAL: begin
                  r.old_limit = softg[e]; softg[e] = q.limit_value;
               end
               pslt_pkg::KIND_SOFT_LOCAL: begin
                  r.old_limit = softl[e]; softl[e] = q.limit_value;
               end
               default: ;
            endcase
            release_if_empty(e);
         end
         pslt_pkg::OP_GET: begin
            e = find(k);
            if (e >= 0) begin
               r.hard_limit = hard[e];
               r.soft_global_limit = softg[e];
               r.soft_local_limit = softl[e];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function void note_request(pslt_pkg::req_type q);
      pending_results.push_back(apply_operation(q));
   endfunction

   function void check_result(pslt_pkg::rsp_type a);
      pslt_pkg::rsp_type e;
      bit bad;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", a);
         return;
      end
      e = pending_results.pop_front();
      bad = a.verdict !== e.verdict || a.verdict_scope !== e.verdict_scope ||
            a.verdict_source !== e.verdict_source || a.old_limit !== e.old_limit ||
            a.hard_limit !== e.hard_limit || a.soft_global_limit !== e.soft_global_limit ||
            a.soft_local_limit !== e.soft_local_limit || a.table_full !== e.table_full;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: exp v%0d sc%0d src%0d old%0d hl%0d sg%0d sl%0d tf%0d, got v%0d sc%0d src%0d old%0d hl%0d sg%0d sl%0d tf%0d",
                     e.verdict, e.verdict_scope, e.verdict_source, e.old_limit, e.hard_limit,
                     e.soft_global_limit, e.soft_local_limit, e.table_full,
                     a.verdict, a.verdict_scope, a.verdict_source, a.old_limit, a.hard_limit,
                     a.soft_global_limit, a.soft_local_limit, a.table_full);
      end
   endfunction
endclass

module testbench;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   limit_scoreboard sb = new();
   bit idle_en = 1;
   int quiet_cycles = 0;
   int fresh_host = 0;

   per_source_connection_limit_table DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // receiver with random stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(pslt_pkg::rsp_type'(rsp_tdata[69:0]));
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(pslt_pkg::req_type q);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= q.opcode;
      req_tdata <= {4'b0, q.limit_value, q.limit_kind, q.class_site_limit,
                    q.class_host_limit, q.is_local, q.key_is_site, q.address};
      do @(posedge clock); while (!req_tready);
      sb.note_request(q);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_defaults(logic [15:0] hl, logic [15:0] hg,
                                 logic [15:0] sl, logic [15:0] sg);
      logic [15:0] v [4];
      v = '{hl, hg, sl, sg};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1; csr_index <= i[1:0]; csr_wdata <= v[i];
         sb.write_default(i[1:0], v[i]);
         @(posedge clock);
      end
      csr_we <= 0;
   endtask

   function automatic pslt_pkg::req_type mk(logic [2:0] op, logic [31:0] a, logic site,
                                            logic loc, logic [15:0] ch, logic [15:0] cs,
                                            logic [1:0] kind, logic [15:0] val);
      pslt_pkg::req_type q;
      q.opcode = op; q.address = a; q.key_is_site = site; q.is_local = loc;
      q.class_host_limit = ch; q.class_site_limit = cs;
      q.limit_kind = kind; q.limit_value = val;
      return q;
   endfunction

   function automatic logic [15:0] small_or_wide();
      case ($urandom_range(0, 9))
         0: return 16'(0);
         1: return 16'($urandom);
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 5));
      endcase
   endfunction

   function automatic pslt_pkg::req_type random_item();
      pslt_pkg::req_type q;
      int pick;
      q = pslt_pkg::req_type'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 9) != 0)
         q.address = {8'd10, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                      8'($urandom_range(0, 5))};
      pick = $urandom_range(0, 99);
      if (pick < 30) q.opcode = pslt_pkg::OP_ADD;
      else if (pick < 50) q.opcode = pslt_pkg::OP_REMOVE;
      else if (pick < 75) q.opcode = pslt_pkg::OP_CHECK;
      else if (pick < 90) q.opcode = pslt_pkg::OP_SET;
      else if (pick < 97) q.opcode = pslt_pkg::OP_GET;
      else q.opcode = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 3) != 0) begin
         q.class_host_limit = small_or_wide();
         q.class_site_limit = small_or_wide();
         q.limit_value = small_or_wide();
      end
      return q;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         send_item(random_item());
         if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      write_defaults(16'd0, 16'd0, 16'd0, 16'd0);

      // directed opening
      send_item(mk(pslt_pkg::OP_CHECK, 32'h0, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_ADD, 32'hFFFFFFFF, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_CHECK, 32'hFFFFFFFF, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_SET, 32'hFFFFFFFF, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_SOFT_GLOBAL, 16'hFFFF));
      send_item(mk(pslt_pkg::OP_SET, 32'hFFFFFFFF, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd7));
      send_item(mk(pslt_pkg::OP_GET, 32'hFFFFFFFF, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_SET, 32'hFFFFFF00, 1, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_SOFT_LOCAL, 16'hFFFF));
      send_item(mk(pslt_pkg::OP_GET, 32'hFFFFFF12, 1, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_SET, 32'h00000001, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_NONE, 16'hFFFF));
      send_item(mk(pslt_pkg::OP_GET, 32'h00000001, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_REMOVE, 32'h00000001, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_ADD, 32'h0A000001, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_CHECK, 32'h0A000001, 0, 0, 16'd1, 16'd1,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_CHECK, 32'h0A000002, 0, 0, 16'hFFFF, 16'd1,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_CHECK, 32'h0A000002, 0, 0, 16'hFFFF, 16'hFFFF,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_REMOVE, 32'h0A000002, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_REMOVE, 32'h0A000001, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_REMOVE, 32'h0A000001, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(3'd5, 32'h0A000001, 1, 1, 16'hFFFF, 16'hFFFF,
                   pslt_pkg::KIND_NONE, 16'hFFFF));
      send_item(mk(3'd7, 32'hFFFFFFFF, 1, 1, 16'hFFFF, 16'hFFFF,
                   pslt_pkg::KIND_NONE, 16'hFFFF));
      send_item(mk(pslt_pkg::OP_SET, 32'hFFFFFFFF, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      drain();

      write_defaults(16'd2, 16'd3, 16'd4, 16'd6);
      random_phase(100);
      write_defaults(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(60);
      write_defaults(16'd1, 16'd0, 16'hFFFF, 16'd2);
      random_phase(40);

      // fill the table with unique host entries, then probe full behaviour
      idle_en = 0;
      write_defaults(16'd3, 16'd5, 16'd0, 16'd8);
      while (sb.used_count() < 1023) begin
         send_item(mk(pslt_pkg::OP_SET, {8'd172, 8'd16, 16'(fresh_host)}, 0, 0, 16'd0,
                      16'd0, pslt_pkg::KIND_SOFT_LOCAL, 16'd1));
         fresh_host++;
      end
      send_item(mk(pslt_pkg::OP_ADD, 32'hC0A80101, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_SET, 32'hC0A80101, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd9));
      send_item(mk(pslt_pkg::OP_ADD, 32'hC0A80202, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_SET, 32'hC0A80202, 1, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_SOFT_GLOBAL, 16'd4));
      send_item(mk(pslt_pkg::OP_ADD, 32'hC0A80101, 0, 1, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      send_item(mk(pslt_pkg::OP_CHECK, 32'hC0A80101, 0, 0, 16'd0, 16'd0,
                   pslt_pkg::KIND_HARD, 16'd0));
      random_phase(20);

      drain();
      repeat (1100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
